>>> rtl/bswc_pkg.sv
// ============================================================================
// bswc_pkg
// Shared types and constants for the bubble sort unit with counters.
// ============================================================================
package bswc_pkg;

    // Default element capacity of the store
    localparam int DEPTH_DEFAULT = 64;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int CMP_W   = 11;
    localparam int MOV_W   = 13;

    // Move count added for each swap
    localparam logic [MOV_W-1:0] MOVES_PER_SWAP = MOV_W'(3);

    // One input item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    // One result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      final_res;
        logic [CMP_W-1:0]          compare_count;
        logic [MOV_W-1:0]          move_count;
        logic                      overflow;
    } result_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // store the accepted item
        logic sort_init;   // clear counts and indexes
        logic pass_start;  // read top element, set k to n-1
        logic pass_load;   // take top element as carry, read k-1
        logic compare;     // one compare and write-back step
        logic pass_end;    // write carry to bottom of pass, advance pass
        logic out_read;    // read next sorted element
        logic run_end;     // clear element count and drop flag
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic n_small;     // fewer than two elements stored
        logic step_last;   // current compare is the last of the pass
        logic pass_last;   // current pass is the last one
        logic out_last;    // current read is the last element
    } status_t;

endpackage

>>> rtl/bswc_ctrl.sv
// ============================================================================
// bswc_ctrl
// Sequencer for load, bubble sort passes and result readout.
// ============================================================================
module bswc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              item_last,
    input  bswc_pkg::status_t status,
    output bswc_pkg::cmd_t    cmd,
    output logic              busy
);

    typedef enum logic [2:0] {
        IDLE,
        SORT_INIT,
        PASS_START,
        PASS_LOAD,
        COMPARE,
        PASS_END,
        OUT_READ,
        OUT_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (item_last)
                    begin
                        state_next = SORT_INIT;
                    end
                end
            end
            SORT_INIT:
            begin
                cmd.sort_init = 1'b1;
                state_next    = status.n_small ? OUT_READ : PASS_START;
            end
            PASS_START:
            begin
                cmd.pass_start = 1'b1;
                state_next     = PASS_LOAD;
            end
            PASS_LOAD:
            begin
                cmd.pass_load = 1'b1;
                state_next    = COMPARE;
            end
            COMPARE:
            begin
                cmd.compare = 1'b1;
                if (status.step_last)
                begin
                    state_next = PASS_END;
                end
            end
            PASS_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = status.pass_last ? OUT_READ : PASS_START;
            end
            OUT_READ:
            begin
                cmd.out_read = 1'b1;
                if (status.out_last)
                begin
                    state_next = OUT_DRAIN;
                end
            end
            OUT_DRAIN:
            begin
                cmd.run_end = 1'b1;
                state_next  = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // Hold state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

>>> rtl/bswc_dpath.sv
// ============================================================================
// bswc_dpath
// Element store, carry compare unit, pass indexes and operation counters.
// ============================================================================
module bswc_dpath #(
    parameter int DEPTH = bswc_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bswc_pkg::cmd_t     cmd,
    input  bswc_pkg::item_t    item,
    output bswc_pkg::status_t  status,
    output bswc_pkg::result_t  result,
    output logic               done
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = bswc_pkg::VALUE_W;

    // Element store, one write and one read port
    logic signed [VW-1:0] mem [DEPTH];

    logic signed [VW-1:0] rdata_reg;
    logic signed [VW-1:0] carry_reg, carry_next;
    logic [AW-1:0]        k_reg, k_next;
    logic [AW-1:0]        p_reg, p_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [bswc_pkg::CMP_W-1:0] cmp_reg, cmp_next;
    logic [bswc_pkg::MOV_W-1:0] mov_reg, mov_next;
    logic                 drop_reg, drop_next;
    logic                 done_reg, done_next;
    logic                 final_reg, final_next;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [VW-1:0] wr_data;
    logic [AW-1:0]        top_idx;
    logic                 less;
    logic                 full;

    assign top_idx = AW'(count_reg - CW'(1));
    assign less    = carry_reg < rdata_reg;
    assign full    = (count_reg == CW'(DEPTH));

    // Status toward the controller
    assign status.n_small   = (count_reg < CW'(2));
    assign status.step_last = (k_reg == AW'(p_reg + AW'(1)));
    assign status.pass_last = ((CW'(p_reg) + CW'(2)) == count_reg);
    assign status.out_last  = ((CW'(j_reg) + CW'(1)) == count_reg);

    // Select read port address
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.pass_start)
        begin
            rd_en   = 1'b1;
            rd_addr = top_idx;
        end
        else if (cmd.pass_load)
        begin
            rd_en   = 1'b1;
            rd_addr = k_reg - AW'(1);
        end
        else if (cmd.compare && !status.step_last)
        begin
            rd_en   = 1'b1;
            rd_addr = k_reg - AW'(2);
        end
        else if (cmd.out_read)
        begin
            rd_en   = 1'b1;
            rd_addr = j_reg;
        end
    end

    // Select write port address and data
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = item.value;
        if (cmd.load)
        begin
            wr_en   = !full;
            wr_addr = count_reg[AW-1:0];
            wr_data = item.value;
        end
        else if (cmd.compare)
        begin
            wr_en   = 1'b1;
            wr_addr = k_reg;
            wr_data = less ? rdata_reg : carry_reg;
        end
        else if (cmd.pass_end)
        begin
            wr_en   = 1'b1;
            wr_addr = p_reg;
            wr_data = carry_reg;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Advance indexes, carry and counters
    always_comb
    begin
        carry_next = carry_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        j_next     = j_reg;
        count_next = count_reg;
        cmp_next   = cmp_reg;
        mov_next   = mov_reg;
        drop_next  = drop_reg;
        done_next  = cmd.out_read;
        final_next = cmd.out_read && status.out_last;

        if (cmd.load)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.sort_init)
        begin
            cmp_next = '0;
            mov_next = '0;
            p_next   = '0;
            j_next   = '0;
        end
        if (cmd.pass_start)
        begin
            k_next = top_idx;
        end
        if (cmd.pass_load)
        begin
            carry_next = rdata_reg;
        end
        if (cmd.compare)
        begin
            cmp_next = cmp_reg + bswc_pkg::CMP_W'(1);
            if (less)
            begin
                mov_next = mov_reg + bswc_pkg::MOVES_PER_SWAP;
            end
            else
            begin
                carry_next = rdata_reg;
            end
            k_next = k_reg - AW'(1);
        end
        if (cmd.pass_end)
        begin
            p_next = p_reg + AW'(1);
        end
        if (cmd.out_read)
        begin
            j_next = j_reg + AW'(1);
        end
        if (cmd.run_end)
        begin
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    // Hold control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cmp_reg   <= '0;
            mov_reg   <= '0;
            drop_reg  <= 1'b0;
            done_reg  <= 1'b0;
            final_reg <= 1'b0;
            k_reg     <= '0;
            p_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
            mov_reg   <= mov_next;
            drop_reg  <= drop_next;
            done_reg  <= done_next;
            final_reg <= final_next;
            k_reg     <= k_next;
            p_reg     <= p_next;
            j_reg     <= j_next;
        end
    end

    // Hold carry payload
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    // Drive result item
    assign result.sorted_value  = rdata_reg;
    assign result.final_res     = final_reg;
    assign result.compare_count = cmp_reg;
    assign result.move_count    = mov_reg;
    assign result.overflow      = drop_reg;
    assign done                 = done_reg;

`ifndef SYNTH
    // No item is loaded while results are being delivered
    a_no_load_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !cmd.load)
        else $error("item loaded during result delivery");

    // Final flag only rides on a result strobe
    a_final_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> done_reg)
        else $error("final flag without result strobe");

    // Element count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // End of run leaves an empty store, a clear drop flag and no result strobe
    a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_end |=> (count_reg == '0) && !drop_reg && !done_reg)
        else $error("run end did not clear state");

    // A compare step always advances the compare count by one
    a_compare_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |=> (cmp_reg == $past(cmp_reg) + bswc_pkg::CMP_W'(1)))
        else $error("compare count did not advance");
`endif

endmodule

>>> rtl/bubble_sort_with_counters_unit.sv
// ============================================================================
// bubble_sort_with_counters_unit
// Collects signed values, bubble sorts them and streams them out with counts.
// ============================================================================
// Load one item per cycle while busy is low; an item marked last ends the run.
// With n elements stored the unit then sorts them, one compare per cycle, as
// set by the single read and single write port of the element store, with a
// pass start, carry load and pass end step around each pass. The n results
// then leave on consecutive cycles, each marked by a one-cycle done strobe
// that the receiver must take as it comes; busy drops the cycle after the
// final result. Items beyond DEPTH are dropped and flagged as overflow.
// ============================================================================
module bubble_sort_with_counters_unit #(
    parameter int DEPTH = bswc_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bswc_pkg::item_t   item,
    output bswc_pkg::result_t result,
    output logic              done
);

    bswc_pkg::cmd_t    cmd;
    bswc_pkg::status_t status;

    // Sequencer
    bswc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_last (item.last),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Store and compare datapath
    bswc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .status (status),
        .result (result),
        .done   (done)
    );

endmodule
